>>> rtl/u8v_pkg.sv
package u8v_pkg;

  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 2;
  localparam int CLASS_W   = 3;

  // Allowed range of the next continuation byte
  localparam logic [CLASS_W-1:0] CLS_PLAIN    = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_AFTER_E0 = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_AFTER_ED = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_AFTER_F0 = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_AFTER_F4 = 3'd4;

  localparam logic [BYTE_W-1:0] CHR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CHR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHR_SP   = 8'h20;
  localparam logic [BYTE_W-1:0] CHR_TILD = 8'h7E;

  localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THR  = 2'd3;

  function automatic logic cont_ok(input logic [BYTE_W-1:0] b,
                                   input logic [CLASS_W-1:0] cls);
    logic ok;
    case (cls)
      CLS_PLAIN:    ok = (b >= 8'h80) && (b <= 8'hBF);
      CLS_AFTER_E0: ok = (b >= 8'hA0) && (b <= 8'hBF);
      CLS_AFTER_ED: ok = (b >= 8'h80) && (b <= 8'h9F);
      CLS_AFTER_F0: ok = (b >= 8'h90) && (b <= 8'hBF);
      CLS_AFTER_F4: ok = (b >= 8'h80) && (b <= 8'h8F);
      default:      ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

>>> rtl/utf8_stream_validator_top.sv
// UTF-8 string checker. Words arrive on the input channel (in_valid,
// in_ready, data_byte), one byte each; a zero byte ends the string. For
// each terminator one word leaves on the output channel (out_valid,
// out_ready, is_valid): 1 when the string was well-formed UTF-8 with
// only tab, LF, CR and printable ASCII among single bytes, else 0.
// Other bytes produce no output word.
// A byte is captured in the input register and checked there; the
// verdict is loaded into the output register as the terminator leaves
// the input register, so out_valid comes straight from a register.
// Throughput is one byte per cycle while no terminator waits for the
// output register; the single state update per byte is the only loop.
// When the receiver stalls, the verdict waits in the output register;
// non-terminator bytes keep flowing, and a second terminator waits in
// the input register, holding back later bytes, until the output
// register frees up.
// Reset (rst, synchronous) empties both registers and starts a new
// string.
module utf8_stream_validator_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [u8v_pkg::BYTE_W-1:0] data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      is_valid
);

  logic                        s1_valid;
  logic [u8v_pkg::BYTE_W-1:0]  s1_byte;
  logic [u8v_pkg::PEND_W-1:0]  bytes_pending, bytes_pending_next;
  logic [u8v_pkg::CLASS_W-1:0] next_range_class, next_range_class_next;
  logic                        error_seen, error_seen_next;
  logic                        s1_term, out_free, s1_advance;

  assign s1_term    = (s1_byte == u8v_pkg::CHR_NUL);
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && (!s1_term || out_free);
  assign in_ready   = !s1_valid || s1_advance;

  always_comb begin
    bytes_pending_next    = bytes_pending;
    next_range_class_next = next_range_class;
    error_seen_next       = error_seen;
    if (s1_term) begin
      bytes_pending_next    = u8v_pkg::PEND_NONE;
      next_range_class_next = u8v_pkg::CLS_PLAIN;
      error_seen_next       = 1'b0;
    end else if (error_seen) begin
      // drop bytes until the terminator
    end else if (bytes_pending != u8v_pkg::PEND_NONE) begin
      if (u8v_pkg::cont_ok(s1_byte, next_range_class)) begin
        bytes_pending_next    = bytes_pending - u8v_pkg::PEND_ONE;
        next_range_class_next = u8v_pkg::CLS_PLAIN;
      end else begin
        error_seen_next       = 1'b1;
        bytes_pending_next    = u8v_pkg::PEND_NONE;
        next_range_class_next = u8v_pkg::CLS_PLAIN;
      end
    end else if (s1_byte == u8v_pkg::CHR_TAB || s1_byte == u8v_pkg::CHR_LF ||
                 s1_byte == u8v_pkg::CHR_CR ||
                 (s1_byte >= u8v_pkg::CHR_SP && s1_byte <= u8v_pkg::CHR_TILD)) begin
      // plain ASCII, nothing to track
    end else if (s1_byte >= 8'hC2 && s1_byte <= 8'hDF) begin
      bytes_pending_next    = u8v_pkg::PEND_ONE;
      next_range_class_next = u8v_pkg::CLS_PLAIN;
    end else if (s1_byte == 8'hE0) begin
      bytes_pending_next    = u8v_pkg::PEND_TWO;
      next_range_class_next = u8v_pkg::CLS_AFTER_E0;
    end else if (s1_byte == 8'hED) begin
      bytes_pending_next    = u8v_pkg::PEND_TWO;
      next_range_class_next = u8v_pkg::CLS_AFTER_ED;
    end else if (s1_byte >= 8'hE1 && s1_byte <= 8'hEF) begin
      bytes_pending_next    = u8v_pkg::PEND_TWO;
      next_range_class_next = u8v_pkg::CLS_PLAIN;
    end else if (s1_byte == 8'hF0) begin
      bytes_pending_next    = u8v_pkg::PEND_THR;
      next_range_class_next = u8v_pkg::CLS_AFTER_F0;
    end else if (s1_byte >= 8'hF1 && s1_byte <= 8'hF3) begin
      bytes_pending_next    = u8v_pkg::PEND_THR;
      next_range_class_next = u8v_pkg::CLS_PLAIN;
    end else if (s1_byte == 8'hF4) begin
      bytes_pending_next    = u8v_pkg::PEND_THR;
      next_range_class_next = u8v_pkg::CLS_AFTER_F4;
    end else begin
      error_seen_next       = 1'b1;
      bytes_pending_next    = u8v_pkg::PEND_NONE;
      next_range_class_next = u8v_pkg::CLS_PLAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      bytes_pending    <= u8v_pkg::PEND_NONE;
      next_range_class <= u8v_pkg::CLS_PLAIN;
      error_seen       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        bytes_pending    <= bytes_pending_next;
        next_range_class <= next_range_class_next;
        error_seen       <= error_seen_next;
      end
      if (s1_advance && s1_term) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
    end
    if (s1_advance && s1_term) begin
      is_valid <= !error_seen && (bytes_pending == u8v_pkg::PEND_NONE);
    end
  end

  a_class_idle: assert property (@(posedge clk) disable iff (rst)
    bytes_pending == u8v_pkg::PEND_NONE |-> next_range_class == u8v_pkg::CLS_PLAIN)
    else $error("range class set with no continuation pending");

  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> bytes_pending == u8v_pkg::PEND_NONE)
    else $error("continuation pending after error");

  a_class_legal: assert property (@(posedge clk) disable iff (rst)
    next_range_class <= u8v_pkg::CLS_AFTER_F4)
    else $error("unused range class reached");

  a_term_resets: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_term |=> !error_seen && bytes_pending == u8v_pkg::PEND_NONE
                              && out_valid)
    else $error("terminator did not restart string state");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_TARGET = 400;
  localparam int QUIET_AFTER = 340;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_N = 24;

  typedef logic [u8v_pkg::BYTE_W-1:0] byte_t;
  typedef enum logic [1:0] {SRC_PREDICT, SRC_GOOD, SRC_BAD} verdict_src_t;
  typedef struct packed {
    byte_t b;
    verdict_src_t src;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  byte_t data_byte;
  logic out_valid;
  logic out_ready;
  logic is_valid;

  utf8_stream_validator_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_valid(is_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [u8v_pkg::PEND_W-1:0] pend_cnt;
  logic [u8v_pkg::CLASS_W-1:0] cont_cls;
  logic err_flag;

  logic verdict_q[$];
  byte_t str_bytes[$];
  dir_row_t dir_rows[DIR_N];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int all_words = 0;
  int strings_sent = 0;
  int good_seen = 0;
  int bad_seen = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  task automatic report_mismatch(input string what, input logic got, input logic exp_v);
    $display("MISMATCH @%0t: %s (got %b, expected %b)", $time, what, got, exp_v);
    err_cnt++;
  endtask

  function automatic bit cont_fits(input byte_t b, input logic [u8v_pkg::CLASS_W-1:0] c);
    byte_t lo, hi;
    lo = 8'h80;
    hi = 8'hBF;
    case (c)
      u8v_pkg::CLS_PLAIN: ;
      u8v_pkg::CLS_AFTER_E0: lo = 8'hA0;
      u8v_pkg::CLS_AFTER_ED: hi = 8'h9F;
      u8v_pkg::CLS_AFTER_F0: lo = 8'h90;
      u8v_pkg::CLS_AFTER_F4: hi = 8'h8F;
      default: return 1'b0;
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic void seq_error();
    err_flag = 1'b1;
    pend_cnt = u8v_pkg::PEND_NONE;
    cont_cls = u8v_pkg::CLS_PLAIN;
  endfunction

  // Advance the checker state by one byte; a terminator yields a verdict.
  function automatic void utf8_track(input byte_t b, output bit due,
                                     output bit verdict);
    due = 1'b0;
    verdict = 1'b0;
    if (b == u8v_pkg::CHR_NUL) begin
      due = 1'b1;
      verdict = !err_flag && (pend_cnt == u8v_pkg::PEND_NONE);
      pend_cnt = u8v_pkg::PEND_NONE;
      cont_cls = u8v_pkg::CLS_PLAIN;
      err_flag = 1'b0;
    end else if (err_flag) begin
      // drop everything until the terminator
    end else if (pend_cnt != u8v_pkg::PEND_NONE) begin
      if (cont_fits(b, cont_cls)) begin
        pend_cnt = pend_cnt - u8v_pkg::PEND_ONE;
        cont_cls = u8v_pkg::CLS_PLAIN;
      end else begin
        seq_error();
      end
    end else if (b == u8v_pkg::CHR_TAB || b == u8v_pkg::CHR_LF || b == u8v_pkg::CHR_CR ||
                 (b >= u8v_pkg::CHR_SP && b <= u8v_pkg::CHR_TILD)) begin
      // plain ASCII, nothing to track
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      pend_cnt = u8v_pkg::PEND_ONE;
      cont_cls = u8v_pkg::CLS_PLAIN;
    end else if (b == 8'hE0) begin
      pend_cnt = u8v_pkg::PEND_TWO;
      cont_cls = u8v_pkg::CLS_AFTER_E0;
    end else if (b == 8'hED) begin
      pend_cnt = u8v_pkg::PEND_TWO;
      cont_cls = u8v_pkg::CLS_AFTER_ED;
    end else if (b >= 8'hE1 && b <= 8'hEF) begin
      pend_cnt = u8v_pkg::PEND_TWO;
      cont_cls = u8v_pkg::CLS_PLAIN;
    end else if (b == 8'hF0) begin
      pend_cnt = u8v_pkg::PEND_THR;
      cont_cls = u8v_pkg::CLS_AFTER_F0;
    end else if (b >= 8'hF1 && b <= 8'hF3) begin
      pend_cnt = u8v_pkg::PEND_THR;
      cont_cls = u8v_pkg::CLS_PLAIN;
    end else if (b == 8'hF4) begin
      pend_cnt = u8v_pkg::PEND_THR;
      cont_cls = u8v_pkg::CLS_AFTER_F4;
    end else begin
      seq_error();
    end
  endfunction

  // Favor the ends of a range.
  function automatic byte_t pick_byte(input byte_t lo, input byte_t hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return byte_t'($urandom_range(lo, hi));
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_byte(input byte_t b, input verdict_src_t src);
    bit due, verdict;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    all_words++;
    utf8_track(b, due, verdict);
    if (due) begin
      case (src)
        SRC_GOOD: verdict_q.push_back(1'b1);
        SRC_BAD: verdict_q.push_back(1'b0);
        default: verdict_q.push_back(verdict);
      endcase
      strings_sent++;
    end
    @(negedge clk);
  endtask

  // Append one well-formed character.
  task automatic add_char();
    byte_t lead, lo1, hi1;
    int n_cont;
    lo1 = 8'h80;
    hi1 = 8'hBF;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        case ($urandom_range(0, 5))
          0: str_bytes.push_back(u8v_pkg::CHR_TAB);
          1: str_bytes.push_back(u8v_pkg::CHR_LF);
          2: str_bytes.push_back(u8v_pkg::CHR_CR);
          default: str_bytes.push_back(pick_byte(u8v_pkg::CHR_SP, u8v_pkg::CHR_TILD));
        endcase
        return;
      end
      3: begin
        lead = pick_byte(8'hC2, 8'hDF);
        n_cont = 1;
      end
      4: begin
        lead = 8'hE0;
        n_cont = 2;
        lo1 = 8'hA0;
      end
      5: begin
        lead = 8'hED;
        n_cont = 2;
        hi1 = 8'h9F;
      end
      6: begin
        lead = $urandom_range(0, 1) ? pick_byte(8'hE1, 8'hEC) : pick_byte(8'hEE, 8'hEF);
        n_cont = 2;
      end
      7: begin
        lead = 8'hF0;
        n_cont = 3;
        lo1 = 8'h90;
      end
      8: begin
        lead = pick_byte(8'hF1, 8'hF3);
        n_cont = 3;
      end
      default: begin
        lead = 8'hF4;
        n_cont = 3;
        hi1 = 8'h8F;
      end
    endcase
    str_bytes.push_back(lead);
    str_bytes.push_back(pick_byte(lo1, hi1));
    repeat (n_cont - 1) str_bytes.push_back(pick_byte(8'h80, 8'hBF));
  endtask

  // Mostly clean strings; some corrupted, cut short, or pure noise.
  task automatic make_string();
    int mode, pos;
    str_bytes.delete();
    mode = $urandom_range(0, 19);
    if (mode < 3) begin
      repeat ($urandom_range(0, 8)) str_bytes.push_back(byte_t'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 6)) add_char();
      if (mode >= 15 && str_bytes.size() > 0) begin
        pos = $urandom_range(0, str_bytes.size() - 1);
        case (mode)
          15, 16: str_bytes[pos] = byte_t'($urandom_range(1, 255));
          17: str_bytes.insert(pos, byte_t'($urandom_range(1, 255)));
          default: begin
            repeat ($urandom_range(1, 2))
              if (str_bytes.size() > 0) void'(str_bytes.pop_back());
          end
        endcase
      end
    end
    str_bytes.push_back(u8v_pkg::CHR_NUL);
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 14) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : verdict_check
    logic exp_v;
    if (!rst && out_valid && out_ready) begin
      if (is_valid) good_seen++;
      else bad_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("verdict with none pending", is_valid, 1'bx);
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_valid !== exp_v) report_mismatch("is_valid", is_valid, exp_v);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_cnt,
               verdict_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n_rand;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = u8v_pkg::CHR_NUL;
    out_ready = 1'b0;
    pend_cnt = u8v_pkg::PEND_NONE;
    cont_cls = u8v_pkg::CLS_PLAIN;
    err_flag = 1'b0;
    n_rand = 0;
    dir_rows = '{
      '{u8v_pkg::CHR_NUL, SRC_GOOD},
      '{8'h41, SRC_PREDICT}, '{u8v_pkg::CHR_NUL, SRC_GOOD},
      '{u8v_pkg::CHR_TAB, SRC_PREDICT}, '{u8v_pkg::CHR_LF, SRC_PREDICT},
      '{u8v_pkg::CHR_CR, SRC_PREDICT}, '{u8v_pkg::CHR_SP, SRC_PREDICT},
      '{u8v_pkg::CHR_TILD, SRC_PREDICT}, '{u8v_pkg::CHR_NUL, SRC_GOOD},
      '{8'h7F, SRC_PREDICT}, '{u8v_pkg::CHR_NUL, SRC_BAD},
      '{8'hFF, SRC_PREDICT}, '{8'h01, SRC_PREDICT}, '{u8v_pkg::CHR_NUL, SRC_BAD},
      '{8'hE0, SRC_PREDICT}, '{8'hA0, SRC_PREDICT}, '{8'h80, SRC_PREDICT},
      '{u8v_pkg::CHR_NUL, SRC_PREDICT},
      '{8'hED, SRC_PREDICT}, '{8'hA0, SRC_PREDICT}, '{8'h80, SRC_PREDICT},
      '{u8v_pkg::CHR_NUL, SRC_PREDICT},
      '{8'hC2, SRC_PREDICT}, '{u8v_pkg::CHR_NUL, SRC_BAD}
    };
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].src);

    while (all_words < WORD_TARGET) begin
      make_string();
      foreach (str_bytes[i]) send_byte(str_bytes[i], SRC_PREDICT);
      n_rand++;
      // hold the sender until the output side has caught up
      if (n_rand == 20) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (verdict_q.size() != 0);
      end
      if (all_words > QUIET_AFTER) quiet = 1'b1;
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (verdict_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d strings (%0d random) over %0d words in %0d cycles",
             strings_sent, n_rand, all_words, cycle_cnt);
    $display("Verdicts: %0d well-formed, %0d rejected, %0d mismatches",
             good_seen, bad_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
